// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define AST_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/xpbd_pkg.sv -----
`default_nettype none
package xpbd_pkg;

    localparam int DEF_PARTICLES   = 1024;
    localparam int DEF_CONSTRAINTS = 1024;
    localparam int IDXW            = 10;

    localparam int DIV_NUMW  = 64;
    localparam int DIV_DENW  = 34;
    localparam int DIV_STEPW = 7;
    localparam int SQ_RADW   = 63;
    localparam int SQ_ROOTW  = 32;
    localparam int SQ_STEPS  = 32;

    localparam logic [31:0] TIME_STEP_RESET = 32'd1092;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ADD   = 2'd1,
        OP_SOLVE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_COMPLIANCE = 1'b0,
        CFG_TIME_STEP  = 1'b1
    } t_cfg;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_SKIP = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE, ST_READ,
        ST_AT1_GO, ST_AT1_WT, ST_AT2_GO, ST_AT2_WT,
        ST_C_RD, ST_C_A, ST_C_B, ST_C_D,
        ST_SQX, ST_SQY, ST_SQ_GO, ST_SQ_WT,
        ST_NX_GO, ST_NX_WT, ST_NY_GO, ST_NY_WT,
        ST_IA_GO, ST_IA_WT, ST_IB_GO, ST_IB_WT,
        ST_W, ST_LM_GO, ST_LM_WT,
        ST_MTX, ST_MTY, ST_MAX, ST_MAY, ST_WA, ST_MBX, ST_MBY, ST_WB,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] m;
    } t_particle;

    typedef struct packed {
        logic [IDXW-1:0] a;
        logic [IDXW-1:0] b;
        logic [31:0]     rest;
    } t_cons;

    typedef struct packed {
        logic                 start;
        logic [DIV_STEPW-1:0] steps;
        logic [DIV_NUMW-1:0]  num;
        logic [DIV_DENW-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic               start;
        logic [SQ_RADW-1:0] rad;
    } t_sqrt_req;

endpackage
`default_nettype wire

// ----- sv/xpbd_div.sv -----
`default_nettype none
module xpbd_div
    import xpbd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_div_req            i_req,
    output logic                     o_done,
    output logic [DIV_NUMW-1:0]      o_quo
);

    logic [DIV_DENW:0]    r_rem;
    logic [DIV_NUMW-1:0]  r_quo;
    logic [DIV_DENW-1:0]  r_den;
    logic [DIV_STEPW-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DENW:0]    w_sh;
    logic                 w_ge;
    logic [DIV_DENW:0]    w_diff;

    always_comb begin
        w_sh   = {r_rem[DIV_DENW-1:0], r_quo[DIV_NUMW-1]};
        w_ge   = w_sh >= {1'b0, r_den};
        w_diff = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEPW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_sh;
            r_quo <= {r_quo[DIV_NUMW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// ----- sv/xpbd_sqrt.sv -----
`default_nettype none
module xpbd_sqrt
    import xpbd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_sqrt_req           i_req,
    output logic                     o_done,
    output logic [SQ_ROOTW-1:0]      o_root
);

    localparam int CNTW = $clog2(SQ_STEPS + 1);

    logic [SQ_RADW-1:0] r_x;
    logic [SQ_RADW-1:0] r_r;
    logic [SQ_RADW-1:0] r_bit;
    logic [CNTW-1:0]    r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [SQ_RADW-1:0] w_trial;
    logic               w_ge;

    always_comb begin
        w_trial = r_r + r_bit;
        w_ge    = r_x >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(SQ_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.rad;
            r_r   <= '0;
            r_bit <= {1'b1, {(SQ_RADW-1){1'b0}}};
        end else if (r_busy) begin
            if (w_ge) begin
                r_x <= r_x - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_ROOTW-1:0];

endmodule
`default_nettype wire

// ----- sv/xpbd_distance_constraint_solver.sv -----
`default_nettype none
// XPBD distance-constraint solver, 2D, Q16.16. Particles (position, previous
// position, mass) live in one single-port-read memory and constraints in a
// second; one word is handled at a time. A solve pass first forms
// compliance/dt^2 on the divider, then works through each constraint on the
// shared radix-2 divider (five divisions of 33 to 49 steps) and the 32-step
// square root; a constraint with an endpoint out of range, or of zero length,
// is skipped and the pass then reports STATUS_SKIP.
module xpbd_distance_constraint_solver
    import xpbd_pkg::*;
#(
    parameter int PARTICLES   = DEF_PARTICLES,
    parameter int CONSTRAINTS = DEF_CONSTRAINTS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // particle_index, other_index, pos_x, pos_y, mass, rest_distance, pad
    input  wire logic [151:0] s_tdata,
    // operation
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, out_pos_x, out_pos_y, out_old_x, out_old_y, pad
    output logic [135:0]      m_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_wdata
);

    `include "assert_macros.svh"

    localparam int PIW = $clog2(PARTICLES);
    localparam int CIW = (CONSTRAINTS > 1) ? $clog2(CONSTRAINTS) : 1;
    localparam int CW  = $clog2(CONSTRAINTS + 1);
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
    localparam logic [31:0] LIM_NEG = 32'h8000_0000;
    localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;

    function automatic logic [31:0] sat_q(input logic [DIV_NUMW-1:0] q, input logic dz,
                                          input logic nz, input logic [31:0] lim);
        logic [31:0] res;
        if (dz) res = nz ? lim : 32'd0;
        else if (q > {32'd0, lim}) res = lim;
        else res = q[31:0];
        return res;
    endfunction

    function automatic logic [31:0] move(input logic [31:0] pos, input logic [47:0] mag,
                                         input logic neg);
        logic signed [49:0] s;
        logic signed [49:0] m;
        logic [31:0]        res;
        m = signed'({2'b0, mag});
        s = signed'({{18{pos[31]}}, pos}) + (neg ? -m : m);
        if (s > 50'sd2147483647) res = LIM_POS;
        else if (s < -50'sd2147483648) res = LIM_NEG;
        else res = s[31:0];
        return res;
    endfunction

    logic [IDXW-1:0] w_pi, w_oi;
    logic [31:0]     w_px, w_py, w_m, w_rest;
    t_op             w_op;
    assign w_pi   = s_tdata[9:0];
    assign w_oi   = s_tdata[19:10];
    assign w_px   = s_tdata[51:20];
    assign w_py   = s_tdata[83:52];
    assign w_m    = s_tdata[115:84];
    assign w_rest = s_tdata[147:116];
    assign w_op   = t_op'(s_tuser);

    t_particle r_pmem [PARTICLES];
    t_cons     r_cmem [CONSTRAINTS];
    t_particle r_prd;
    t_cons     r_crd;

    logic            w_pwe;
    logic [PIW-1:0]  w_pwaddr, w_praddr;
    t_particle       w_pwdata;
    logic            w_cwe;
    logic [CIW-1:0]  w_cwaddr, w_craddr;

    always_ff @(posedge i_clk) begin
        if (w_pwe) r_pmem[w_pwaddr] <= w_pwdata;
        r_prd <= r_pmem[w_praddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cwe) r_cmem[w_cwaddr] <= '{a: w_pi, b: w_oi, rest: w_rest};
        r_crd <= r_cmem[w_craddr];
    end

    t_state        r_state, n_state;
    logic [31:0]   r_compliance, r_time_step;
    logic [CW-1:0] r_count, r_k;
    logic          r_skip, r_oob;
    logic          r_ovalid;
    logic [135:0]  r_odata;
    logic [31:0]   r_at;
    t_cons         r_cons;
    t_particle     r_pa, r_pb;
    logic [32:0]   r_ux, r_uy;
    logic          r_xneg, r_yneg, r_sh;
    logic [61:0]   r_sqx, r_sqy;
    logic [32:0]   r_len;
    logic [16:0]   r_nx, r_ny;
    logic [31:0]   r_ia, r_ib, r_lm, r_tx, r_ty;
    logic [33:0]   r_w;
    logic [32:0]   r_cm;
    logic          r_lneg;
    logic [47:0]   r_mx, r_my;

    t_div_req            w_div;
    logic                w_div_done;
    logic [DIV_NUMW-1:0] w_quo;
    t_sqrt_req           w_sq;
    logic                w_sq_done;
    logic [SQ_ROOTW-1:0] w_root;

    xpbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    xpbd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sq),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    logic        w_acc;
    logic        w_oset;
    logic [32:0] w_mul_a, w_mul_b;
    logic [65:0] w_mul;
    logic [31:0] w_hx, w_hy;
    logic        w_bad;
    logic [32:0] w_dx, w_dy;
    logic [32:0] w_len;
    logic signed [34:0] w_c;

    assign w_acc = s_tvalid && s_tready;
    assign w_oset = (r_state == ST_IDLE && w_acc && (w_op == OP_WRITE || w_op == OP_ADD)) ||
                    r_state == ST_READ || r_state == ST_DONE;
    assign w_hx  = r_sh ? r_ux[32:1] : r_ux[31:0];
    assign w_hy  = r_sh ? r_uy[32:1] : r_uy[31:0];
    assign w_mul = w_mul_a * w_mul_b;
    assign w_bad = (32'(r_crd.a) >= PARTICLES) || (32'(r_crd.b) >= PARTICLES);
    assign w_dx  = {r_pa.x[31], r_pa.x} - {r_prd.x[31], r_prd.x};
    assign w_dy  = {r_pa.y[31], r_pa.y} - {r_prd.y[31], r_prd.y};
    assign w_len = r_sh ? {w_root, 1'b0} : {1'b0, w_root};
    assign w_c   = signed'({2'b0, r_len}) - signed'({3'b0, r_cons.rest});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    priority case (w_op)
                        OP_READ:  n_state = ST_READ;
                        OP_SOLVE: n_state = ST_AT1_GO;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   n_state = ST_IDLE;
            ST_AT1_GO: n_state = ST_AT1_WT;
            ST_AT1_WT: if (w_div_done) n_state = ST_AT2_GO;
            ST_AT2_GO: n_state = ST_AT2_WT;
            ST_AT2_WT: if (w_div_done) n_state = ST_C_RD;
            ST_C_RD:   n_state = (r_k < r_count) ? ST_C_A : ST_DONE;
            ST_C_A:    n_state = w_bad ? ST_C_RD : ST_C_B;
            ST_C_B:    n_state = ST_C_D;
            ST_C_D:    n_state = ST_SQX;
            ST_SQX:    n_state = ST_SQY;
            ST_SQY:    n_state = ST_SQ_GO;
            ST_SQ_GO:  n_state = ST_SQ_WT;
            ST_SQ_WT:  if (w_sq_done) n_state = (w_len == '0) ? ST_C_RD : ST_NX_GO;
            ST_NX_GO:  n_state = ST_NX_WT;
            ST_NX_WT:  if (w_div_done) n_state = ST_NY_GO;
            ST_NY_GO:  n_state = ST_NY_WT;
            ST_NY_WT:  if (w_div_done) n_state = ST_IA_GO;
            ST_IA_GO:  n_state = ST_IA_WT;
            ST_IA_WT:  if (w_div_done) n_state = ST_IB_GO;
            ST_IB_GO:  n_state = ST_IB_WT;
            ST_IB_WT:  if (w_div_done) n_state = ST_W;
            ST_W:      n_state = ST_LM_GO;
            ST_LM_GO:  n_state = ST_LM_WT;
            ST_LM_WT:  if (w_div_done) n_state = ST_MTX;
            ST_MTX:    n_state = ST_MTY;
            ST_MTY:    n_state = ST_MAX;
            ST_MAX:    n_state = ST_MAY;
            ST_MAY:    n_state = ST_WA;
            ST_WA:     n_state = ST_MBX;
            ST_MBX:    n_state = ST_MBY;
            ST_MBY:    n_state = ST_WB;
            ST_WB:     n_state = ST_C_RD;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (r_state == ST_IDLE) && (!r_ovalid || m_tready);
        w_praddr = PIW'(w_pi);
        w_craddr = CIW'(r_k);
        w_pwe    = 1'b0;
        w_pwaddr = PIW'(w_pi);
        w_pwdata = '{x: w_px, y: w_py, ox: w_px, oy: w_py, m: w_m};
        w_cwe    = 1'b0;
        w_cwaddr = CIW'(r_count);
        w_div    = '{start: 1'b0, steps: '0, num: '0, den: '0};
        w_sq     = '{start: 1'b0, rad: SQ_RADW'({1'b0, r_sqx} + {1'b0, r_sqy})};
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_pwe = w_acc && (w_op == OP_WRITE) && (32'(w_pi) < PARTICLES);
                w_cwe = w_acc && (w_op == OP_ADD) && (32'(r_count) < CONSTRAINTS);
            end
            ST_AT1_GO: w_div = '{start: 1'b1, steps: DIV_STEPW'(48),
                                 num: {r_compliance, 32'd0}, den: {2'b0, r_time_step}};
            ST_AT2_GO: w_div = '{start: 1'b1, steps: DIV_STEPW'(48),
                                 num: {r_at, 32'd0}, den: {2'b0, r_time_step}};
            ST_C_A:    w_praddr = PIW'(r_crd.a);
            ST_C_B:    w_praddr = PIW'(r_cons.b);
            ST_SQX: begin
                w_mul_a = {1'b0, w_hx};
                w_mul_b = {1'b0, w_hx};
            end
            ST_SQY: begin
                w_mul_a = {1'b0, w_hy};
                w_mul_b = {1'b0, w_hy};
            end
            ST_SQ_GO:  w_sq.start = 1'b1;
            ST_NX_GO:  w_div = '{start: 1'b1, steps: DIV_STEPW'(49),
                                 num: {r_ux, 31'd0}, den: {1'b0, r_len}};
            ST_NY_GO:  w_div = '{start: 1'b1, steps: DIV_STEPW'(49),
                                 num: {r_uy, 31'd0}, den: {1'b0, r_len}};
            ST_IA_GO:  w_div = '{start: 1'b1, steps: DIV_STEPW'(33),
                                 num: {1'b1, 63'd0}, den: {2'b0, r_pa.m}};
            ST_IB_GO:  w_div = '{start: 1'b1, steps: DIV_STEPW'(33),
                                 num: {1'b1, 63'd0}, den: {2'b0, r_pb.m}};
            ST_LM_GO:  w_div = '{start: 1'b1, steps: DIV_STEPW'(49),
                                 num: {r_cm, 31'd0}, den: r_w};
            ST_MTX: begin
                w_mul_a = {16'd0, r_nx};
                w_mul_b = {1'b0, r_lm};
            end
            ST_MTY: begin
                w_mul_a = {16'd0, r_ny};
                w_mul_b = {1'b0, r_lm};
            end
            ST_MAX: begin
                w_mul_a = {1'b0, r_tx};
                w_mul_b = {1'b0, r_ia};
            end
            ST_MAY: begin
                w_mul_a = {1'b0, r_ty};
                w_mul_b = {1'b0, r_ia};
            end
            ST_MBX: begin
                w_mul_a = {1'b0, r_tx};
                w_mul_b = {1'b0, r_ib};
            end
            ST_MBY: begin
                w_mul_a = {1'b0, r_ty};
                w_mul_b = {1'b0, r_ib};
            end
            ST_WA: begin
                w_pwe    = 1'b1;
                w_pwaddr = PIW'(r_cons.a);
                w_pwdata = '{x: move(r_pa.x, r_mx, r_xneg ^ r_lneg),
                             y: move(r_pa.y, r_my, r_yneg ^ r_lneg),
                             ox: r_pa.x, oy: r_pa.y, m: r_pa.m};
            end
            ST_WB: begin
                w_pwe    = 1'b1;
                w_pwaddr = PIW'(r_cons.b);
                w_pwdata = '{x: move(r_pb.x, r_mx, !r_xneg ^ r_lneg),
                             y: move(r_pb.y, r_my, !r_yneg ^ r_lneg),
                             ox: r_pb.x, oy: r_pb.y, m: r_pb.m};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_compliance <= '0;
            r_time_step  <= TIME_STEP_RESET;
            r_count      <= '0;
            r_k          <= '0;
            r_skip       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg'(i_cfg_idx))
                    CFG_COMPLIANCE: r_compliance <= i_cfg_wdata;
                    CFG_TIME_STEP:  r_time_step  <= i_cfg_wdata;
                    default:        r_compliance <= i_cfg_wdata;
                endcase
            end
            if (w_oset) r_ovalid <= 1'b1;
            else if (m_tready) r_ovalid <= 1'b0;
            if (r_state == ST_IDLE && w_acc) begin
                unique case (w_op)
                    OP_WRITE: begin
                    end
                    OP_ADD: begin
                        if (32'(r_count) < CONSTRAINTS) r_count <= r_count + 1'b1;
                    end
                    OP_SOLVE: begin
                        r_k    <= '0;
                        r_skip <= 1'b0;
                    end
                    OP_READ: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_C_A && w_bad) begin
                r_skip <= 1'b1;
                r_k    <= r_k + 1'b1;
            end
            if (r_state == ST_SQ_WT && w_sq_done && w_len == '0) begin
                r_skip <= 1'b1;
                r_k    <= r_k + 1'b1;
            end
            if (r_state == ST_WB) r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_oob <= 32'(w_pi) >= PARTICLES;
                if (w_acc)
                    r_odata <= {134'd0, (w_op == OP_ADD && 32'(r_count) >= CONSTRAINTS) ?
                                        STATUS_FULL : STATUS_OK};
            end
            ST_READ: begin
                r_odata <= r_oob ? 136'd0 :
                           {6'd0, r_prd.oy, r_prd.ox, r_prd.y, r_prd.x, STATUS_OK};
            end
            ST_AT1_WT: if (w_div_done)
                r_at <= sat_q(w_quo, r_time_step == '0, r_compliance != '0, SAT32);
            ST_AT2_WT: if (w_div_done)
                r_at <= sat_q(w_quo, r_time_step == '0, r_at != '0, SAT32);
            ST_C_A:    r_cons <= r_crd;
            ST_C_B:    r_pa <= r_prd;
            ST_C_D: begin
                r_pb   <= r_prd;
                r_xneg <= w_dx[32];
                r_yneg <= w_dy[32];
                r_ux   <= w_dx[32] ? -w_dx : w_dx;
                r_uy   <= w_dy[32] ? -w_dy : w_dy;
                r_sh   <= (w_dx[32] ? -w_dx : w_dx) >= 33'h0_8000_0000 ||
                          (w_dy[32] ? -w_dy : w_dy) >= 33'h0_8000_0000;
            end
            ST_SQX:    r_sqx <= w_mul[61:0];
            ST_SQY:    r_sqy <= w_mul[61:0];
            ST_SQ_WT:  if (w_sq_done) r_len <= w_len;
            ST_NX_WT:  if (w_div_done)
                r_nx <= (w_quo > 64'd65536) ? 17'd65536 : w_quo[16:0];
            ST_NY_WT:  if (w_div_done)
                r_ny <= (w_quo > 64'd65536) ? 17'd65536 : w_quo[16:0];
            ST_IA_WT:  if (w_div_done) r_ia <= sat_q(w_quo, r_pa.m == '0, 1'b1, SAT32);
            ST_IB_WT:  if (w_div_done) r_ib <= sat_q(w_quo, r_pb.m == '0, 1'b1, SAT32);
            ST_W: begin
                r_w    <= {2'b0, r_ia} + {2'b0, r_ib} + {2'b0, r_at};
                r_lneg <= (w_c > 35'sd0);
                r_cm   <= w_c[34] ? 33'(-w_c) : w_c[32:0];
            end
            ST_LM_WT:  if (w_div_done)
                r_lm <= sat_q(w_quo, 1'b0, 1'b1, r_lneg ? LIM_NEG : LIM_POS);
            ST_MTX:    r_tx <= w_mul[47:16];
            ST_MTY:    r_ty <= w_mul[47:16];
            ST_MAX, ST_MBX: r_mx <= w_mul[63:16];
            ST_MAY, ST_MBY: r_my <= w_mul[63:16];
            ST_DONE: begin
                r_odata <= {134'd0, r_skip ? STATUS_SKIP : STATUS_OK};
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;

    `AST_IMPL(a_ready_idle, i_clk, i_rst_n, s_tready, r_state == ST_IDLE)
    `AST_ALWAYS(a_count_bound, i_clk, i_rst_n, 32'(r_count) <= CONSTRAINTS)
    `AST_ALWAYS(a_k_bound, i_clk, i_rst_n, r_k <= r_count)
    `AST_IMPL(a_wb_pair, i_clk, i_rst_n, r_state == ST_WB, r_cons.a != r_cons.b)

endmodule
`default_nettype wire
